// ----- hdl/ss_step_pkg.sv -----
// ss_step_pkg: payload structs, function codes and register indexes for the
// state-space step block; no dependencies
`default_nettype none

package ss_step_pkg;

   // fixed field and datapath widths
   localparam int VALUE_W     = 32;
   localparam int ACC_W       = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int FRAC_MAX    = 30;

   // request function codes
   localparam logic [1:0] FUNC_LOAD_COEF = 2'd0;
   localparam logic [1:0] FUNC_SET_STATE = 2'd1;
   localparam logic [1:0] FUNC_REPORT    = 2'd2;
   localparam logic [1:0] FUNC_INPUT     = 2'd3;

   // coefficient matrix select
   localparam logic [1:0] MSEL_A = 2'd0;
   localparam logic [1:0] MSEL_B = 2'd1;
   localparam logic [1:0] MSEL_C = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STATES_USED  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INPUTS_USED  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUTS_USED = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAC_BITS    = 2'd3;

   // result kinds
   localparam logic KIND_STATE  = 1'b0;
   localparam logic KIND_OUTPUT = 1'b1;

   typedef struct packed {
      logic [1:0]                func;
      logic [1:0]                matrix_sel;
      logic [1:0]                row;
      logic [1:0]                col;
      logic signed [VALUE_W-1:0] value;
      logic                      last_input;
   } req_type;

   typedef struct packed {
      logic                      kind;
      logic [1:0]                index;
      logic signed [VALUE_W-1:0] result_value;
      logic                      overflow;
      logic                      last;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/state_space_step.sv -----
// state_space_step: discrete linear state-space update x = A x + B u, y = C x
// in signed fixed point; depends on ss_step_pkg
//
// Coefficients A, B and C sit in one synchronous memory, the state and input
// vectors in a second one; a single multiplier with a four-stage
// read/multiply/accumulate/finish pipeline computes every dot product, one
// term per cycle. After reset the block sweeps both memories to zero and
// holds req_stall high meanwhile; csr writes are taken at any time.
// Coefficient loads, state sets and non-final input elements are written
// in ST_IDLE and leave the block there. An update or a report is paced by the
// one shared multiplier taking one term per cycle and by the results leaving
// one per cycle while rsp_stall is low. Results go out through an output
// register, so the next request can be taken while the last result of a run
// still waits.
`default_nettype none

module state_space_step
   import ss_step_pkg::*;
#(
   parameter int MAX_STATES  = 4,
   parameter int MAX_INPUTS  = 2,
   parameter int MAX_OUTPUTS = 2,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // memory layout
   localparam int B_BASE     = MAX_STATES * MAX_STATES;
   localparam int C_BASE     = B_BASE + MAX_STATES * MAX_INPUTS;
   localparam int COEF_DEPTH = C_BASE + MAX_OUTPUTS * MAX_STATES;
   localparam int IN_BASE    = MAX_STATES;
   localparam int VEC_DEPTH  = MAX_STATES + MAX_INPUTS;
   localparam int CA_W       = $clog2(COEF_DEPTH);
   localparam int VA_W       = $clog2(VEC_DEPTH);

   // index and counter widths
   localparam int SI_W  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int SO_W  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int RI_W  = (SI_W > SO_W) ? SI_W : SO_W;
   localparam int CNT_W = $clog2(MAX_STATES + MAX_INPUTS + MAX_OUTPUTS + 1);

   // saturation bounds
   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_UPD      = 9'b000000100,
      ST_UPD_WAIT = 9'b000001000,
      ST_WB       = 9'b000010000,
      ST_LOADX    = 9'b000100000,
      ST_CY       = 9'b001000000,
      ST_CY_WAIT  = 9'b010000000,
      ST_EMIT     = 9'b100000000
   } state_type;

   typedef struct packed {
      logic            vld;
      logic            first;
      logic            last;
      logic            to_y;
      logic [RI_W-1:0] idx;
   } tag_type;

   // clamp a count register into 1..hi
   function automatic logic [CNT_W-1:0] clamp_count(input logic [2:0] v, input int hi);
      int c;
      c = int'(v);
      if (c < 1) c = 1;
      if (c > hi) c = hi;
      return CNT_W'(c);
   endfunction

   // configuration registers
   logic [2:0] su_ff;
   logic [1:0] iu_ff;
   logic [1:0] ou_ff;
   logic [4:0] fb_ff;
   logic [CNT_W-1:0] n_cnt, m_cnt, r_cnt;
   logic [4:0] frac_eff;

   // sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] emit_ff, emit_in;
   logic [CA_W-1:0]  clr_ff, clr_in;
   logic             req_accept;

   // memories
   logic signed [DATA_WIDTH-1:0] coef_mem [COEF_DEPTH];
   logic signed [DATA_WIDTH-1:0] vec_mem [VEC_DEPTH];
   logic                         coef_we, vec_we;
   logic [CA_W-1:0]              coef_waddr, coef_raddr;
   logic [VA_W-1:0]              vec_waddr, vec_raddr;
   logic signed [DATA_WIDTH-1:0] coef_wdata, vec_wdata;
   logic signed [DATA_WIDTH-1:0] coef_q_ff, vec_q_ff;

   // mac pipeline
   tag_type                        iss, p1_ff, p2_ff, p3_ff;
   logic                           pipe_busy;
   logic signed [2*DATA_WIDTH-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic signed [ACC_W-1:0]        fin_shift;
   logic signed [DATA_WIDTH-1:0]   fin_val;
   logic                           fin_ovf;

   // state reload from memory for a report
   logic            ld_vld_ff, ld_vld_in;
   logic [SI_W-1:0] ld_idx_ff, ld_idx_in;

   // result buffers
   logic signed [DATA_WIDTH-1:0] nx_ff [MAX_STATES];
   logic [MAX_STATES-1:0]        sovf_ff;
   logic signed [DATA_WIDTH-1:0] y_ff [MAX_OUTPUTS];
   logic [MAX_OUTPUTS-1:0]       yovf_ff;
   logic                         sovf_clr;
   logic [SI_W-1:0]              nx_ridx;
   logic signed [DATA_WIDTH-1:0] nx_rd;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          out_item;
   logic             out_free, out_load;
   logic             emit_is_state, emit_last;
   logic [CNT_W-1:0] emit_sub;
   logic [SO_W-1:0]  y_idx;
   logic signed [DATA_WIDTH-1:0] emit_val;

   // effective counts and fraction bits
   assign n_cnt    = clamp_count(su_ff, MAX_STATES);
   assign m_cnt    = clamp_count({1'b0, iu_ff}, MAX_INPUTS);
   assign r_cnt    = clamp_count({1'b0, ou_ff}, MAX_OUTPUTS);
   assign frac_eff = (fb_ff > 5'(FRAC_MAX)) ? 5'(FRAC_MAX) : fb_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign pipe_busy  = p1_ff.vld || p2_ff.vld || p3_ff.vld;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // sequencer and memory port control
   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      emit_in    = emit_ff;
      clr_in     = clr_ff;
      iss        = '0;
      coef_raddr = '0;
      vec_raddr  = '0;
      coef_we    = 1'b0;
      coef_waddr = '0;
      coef_wdata = '0;
      vec_we     = 1'b0;
      vec_waddr  = '0;
      vec_wdata  = '0;
      ld_vld_in  = 1'b0;
      ld_idx_in  = row_ff[SI_W-1:0];
      sovf_clr   = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            coef_we    = 1'b1;
            coef_waddr = clr_ff;
            vec_we     = (int'(clr_ff) < VEC_DEPTH);
            vec_waddr  = clr_ff[VA_W-1:0];
            if (clr_ff == CA_W'(COEF_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + CA_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.func)
                  FUNC_LOAD_COEF: begin
                     coef_wdata = req_data.value[DATA_WIDTH-1:0];
                     case (req_data.matrix_sel)
                        MSEL_A: begin
                           coef_we    = (int'(req_data.row) < MAX_STATES) &&
                                        (int'(req_data.col) < MAX_STATES);
                           coef_waddr = CA_W'(int'(req_data.row) * MAX_STATES +
                                              int'(req_data.col));
                        end
                        MSEL_B: begin
                           coef_we    = (int'(req_data.row) < MAX_STATES) &&
                                        (int'(req_data.col) < MAX_INPUTS);
                           coef_waddr = CA_W'(B_BASE + int'(req_data.row) * MAX_INPUTS +
                                              int'(req_data.col));
                        end
                        MSEL_C: begin
                           coef_we    = (int'(req_data.row) < MAX_OUTPUTS) &&
                                        (int'(req_data.col) < MAX_STATES);
                           coef_waddr = CA_W'(C_BASE + int'(req_data.row) * MAX_STATES +
                                              int'(req_data.col));
                        end
                        default: begin
                           coef_we = 1'b0;
                        end
                     endcase
                  end
                  FUNC_SET_STATE: begin
                     vec_we    = (int'(req_data.row) < int'(n_cnt));
                     vec_waddr = VA_W'(req_data.row);
                     vec_wdata = req_data.value[DATA_WIDTH-1:0];
                  end
                  FUNC_REPORT: begin
                     sovf_clr = 1'b1;
                     row_in   = '0;
                     state_in = ST_LOADX;
                  end
                  FUNC_INPUT: begin
                     vec_we    = (int'(req_data.col) < int'(m_cnt));
                     vec_waddr = VA_W'(IN_BASE + int'(req_data.col));
                     vec_wdata = req_data.value[DATA_WIDTH-1:0];
                     if (req_data.last_input) begin
                        row_in   = '0;
                        col_in   = '0;
                        state_in = ST_UPD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // one term of x = A x + B u per cycle
         ST_UPD: begin
            iss.vld   = 1'b1;
            iss.first = (col_ff == '0);
            iss.last  = (col_ff == n_cnt + m_cnt - CNT_W'(1));
            iss.to_y  = 1'b0;
            iss.idx   = row_ff[RI_W-1:0];
            if (col_ff < n_cnt) begin
               coef_raddr = CA_W'(int'(row_ff) * MAX_STATES + int'(col_ff));
               vec_raddr  = VA_W'(col_ff);
            end else begin
               coef_raddr = CA_W'(B_BASE + int'(row_ff) * MAX_INPUTS +
                                  int'(col_ff) - int'(n_cnt));
               vec_raddr  = VA_W'(IN_BASE + int'(col_ff) - int'(n_cnt));
            end
            if (iss.last) begin
               col_in = '0;
               if (row_ff == n_cnt - CNT_W'(1)) begin
                  state_in = ST_UPD_WAIT;
               end else begin
                  row_in = row_ff + CNT_W'(1);
               end
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
         ST_UPD_WAIT: begin
            if (!pipe_busy) begin
               row_in   = '0;
               state_in = ST_WB;
            end
         end
         // write the new state back to memory
         ST_WB: begin
            vec_we    = 1'b1;
            vec_waddr = VA_W'(row_ff);
            vec_wdata = nx_rd;
            if (row_ff == n_cnt - CNT_W'(1)) begin
               row_in   = '0;
               col_in   = '0;
               state_in = ST_CY;
            end else begin
               row_in = row_ff + CNT_W'(1);
            end
         end
         // pull the current state into the result buffer
         ST_LOADX: begin
            vec_raddr = VA_W'(row_ff);
            ld_vld_in = 1'b1;
            if (row_ff == n_cnt - CNT_W'(1)) begin
               row_in   = '0;
               col_in   = '0;
               state_in = ST_CY;
            end else begin
               row_in = row_ff + CNT_W'(1);
            end
         end
         // one term of y = C x per cycle
         ST_CY: begin
            iss.vld    = 1'b1;
            iss.first  = (col_ff == '0);
            iss.last   = (col_ff == n_cnt - CNT_W'(1));
            iss.to_y   = 1'b1;
            iss.idx    = row_ff[RI_W-1:0];
            coef_raddr = CA_W'(C_BASE + int'(row_ff) * MAX_STATES + int'(col_ff));
            vec_raddr  = VA_W'(col_ff);
            if (iss.last) begin
               col_in = '0;
               if (row_ff == r_cnt - CNT_W'(1)) begin
                  state_in = ST_CY_WAIT;
               end else begin
                  row_in = row_ff + CNT_W'(1);
               end
            end else begin
               col_in = col_ff + CNT_W'(1);
            end
         end
         ST_CY_WAIT: begin
            if (!pipe_busy) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_q_ff <= coef_mem[coef_raddr];
   end

   // state and input vector memory
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_waddr] <= vec_wdata;
      end
      vec_q_ff <= vec_mem[vec_raddr];
   end

   // multiply, accumulate, shift and saturate
   assign prod_in   = coef_q_ff * vec_q_ff;
   assign acc_in    = (p2_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
   assign fin_shift = acc_ff >>> frac_eff;

   always_comb begin
      fin_ovf = 1'b0;
      fin_val = fin_shift[DATA_WIDTH-1:0];
      if (fin_shift > SAT_HI) begin
         fin_ovf = 1'b1;
         fin_val = SAT_HI[DATA_WIDTH-1:0];
      end else if (fin_shift < SAT_LO) begin
         fin_ovf = 1'b1;
         fin_val = SAT_LO[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // result buffers: finished dot products and reloaded state
   always_ff @(posedge clock) begin
      if (sovf_clr) begin
         sovf_ff <= '0;
      end
      if (ld_vld_ff) begin
         nx_ff[ld_idx_ff] <= vec_q_ff;
      end
      if (p3_ff.vld && p3_ff.last) begin
         if (p3_ff.to_y) begin
            y_ff[p3_ff.idx[SO_W-1:0]]    <= fin_val;
            yovf_ff[p3_ff.idx[SO_W-1:0]] <= fin_ovf;
         end else begin
            nx_ff[p3_ff.idx[SI_W-1:0]]   <= fin_val;
            sovf_ff[p3_ff.idx[SI_W-1:0]] <= fin_ovf;
         end
      end
   end

   // result selection
   assign nx_ridx       = (state_ff == ST_WB) ? row_ff[SI_W-1:0] : emit_ff[SI_W-1:0];
   assign nx_rd         = nx_ff[nx_ridx];
   assign emit_is_state = (emit_ff < n_cnt);
   assign emit_last     = (emit_ff == n_cnt + r_cnt - CNT_W'(1));
   assign emit_sub      = emit_ff - n_cnt;
   assign y_idx         = emit_sub[SO_W-1:0];
   assign emit_val      = emit_is_state ? nx_rd : y_ff[y_idx];

   always_comb begin
      out_item.kind         = emit_is_state ? KIND_STATE : KIND_OUTPUT;
      out_item.index        = emit_is_state ? 2'(emit_ff) : 2'(emit_sub);
      out_item.result_value = VALUE_W'(emit_val);
      out_item.overflow     = emit_is_state ? sovf_ff[nx_ridx] : yovf_ff[y_idx];
      out_item.last         = emit_last;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_item;
      end
      ld_idx_ff <= ld_idx_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         emit_ff      <= '0;
         clr_ff       <= '0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
         ld_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         emit_ff      <= emit_in;
         clr_ff       <= clr_in;
         p1_ff        <= iss;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         ld_vld_ff    <= ld_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         su_ff <= 3'd4;
         iu_ff <= 2'd2;
         ou_ff <= 2'd2;
         fb_ff <= 5'd16;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_STATES_USED:  su_ff <= csr_wdata[2:0];
            CSR_INPUTS_USED:  iu_ff <= csr_wdata[1:0];
            CSR_OUTPUTS_USED: ou_ff <= csr_wdata[1:0];
            CSR_FRAC_BITS:    fb_ff <= csr_wdata;
            default:          fb_ff <= fb_ff;
         endcase
      end
   end

`ifndef SYNTHESIS
   // results go out only after every dot product has landed
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !pipe_busy)
      else $error("result emission started with the mac pipeline busy");

   // state reload and mac share the vector read register
   a_load_vs_mac: assert property (@(posedge clock) disable iff (reset)
      ld_vld_ff |-> !p1_ff.vld)
      else $error("state reload collides with a mac term");

   // a new result only comes from the emit phase
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result register loaded outside emission");

   // finished sums land only while a computation is running
   a_finish_in_run: assert property (@(posedge clock) disable iff (reset)
      p3_ff.vld |-> (state_ff == ST_UPD || state_ff == ST_UPD_WAIT ||
                     state_ff == ST_CY || state_ff == ST_CY_WAIT))
      else $error("mac result outside an update or output pass");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_state_space_step.sv -----
`timescale 1ns / 1ps
// tb_state_space_step: self-checking testbench for the state-space step block,
// a predictor class with an expected-result queue plus tasks that drive it
// depends on ss_step_pkg and state_space_step
`default_nettype none

module tb_state_space_step;
   import ss_step_pkg::*;

   localparam int MAX_STATES      = 4;
   localparam int MAX_INPUTS      = 2;
   localparam int MAX_OUTPUTS     = 2;
   localparam int DRAIN_CYCLES    = 64;
   localparam int ITEMS_PER_PHASE = 46;
   localparam int NUM_PHASES      = 8;
   localparam realtime TIMEOUT_NS = 5_000_000.0;

   // matrix select with no matrix behind it
   localparam logic [1:0] MSEL_NONE = 2'd3;

   // idling styles
   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   // predictor of the block plus the queue of results still to arrive
   class ss_step_tracker;
      longint           coef_a [MAX_STATES*MAX_STATES];
      longint           coef_b [MAX_STATES*MAX_INPUTS];
      longint           coef_c [MAX_OUTPUTS*MAX_STATES];
      longint           state_vec [MAX_STATES];
      longint           input_vec [MAX_INPUTS];
      logic [2:0]       states_used;
      logic [1:0]       inputs_used;
      logic [1:0]       outputs_used;
      logic [4:0]       frac_bits;
      rsp_type          pending_rsps[$];
      int               error_count;

      function new();
         foreach (coef_a[k]) coef_a[k] = 0;
         foreach (coef_b[k]) coef_b[k] = 0;
         foreach (coef_c[k]) coef_c[k] = 0;
         foreach (state_vec[k]) state_vec[k] = 0;
         foreach (input_vec[k]) input_vec[k] = 0;
         states_used  = 3'd4;
         inputs_used  = 2'd2;
         outputs_used = 2'd2;
         frac_bits    = 5'd16;
         error_count  = 0;
      endfunction

      // zero counts act as one, oversized counts as the maximum
      function int unsigned clamp_count(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned used_states();
         return clamp_count(states_used, MAX_STATES);
      endfunction

      function int unsigned used_inputs();
         return clamp_count(inputs_used, MAX_INPUTS);
      endfunction

      function int unsigned used_outputs();
         return clamp_count(outputs_used, MAX_OUTPUTS);
      endfunction

      function int unsigned used_frac();
         return (frac_bits > FRAC_MAX) ? FRAC_MAX : frac_bits;
      endfunction

      function void write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_STATES_USED:  states_used  = data[2:0];
            CSR_INPUTS_USED:  inputs_used  = data[1:0];
            CSR_OUTPUTS_USED: outputs_used = data[1:0];
            CSR_FRAC_BITS:    frac_bits    = data[4:0];
            default:          ;
         endcase
      endfunction

      // append one expected result at the tail of the queue
      function void queue_expected(rsp_type rsp);
         pending_rsps.insert(pending_rsps.size(), rsp);
      endfunction

      // arithmetic shift of the wrapped 64-bit sum, then saturate to 32 bits
      function void scale_sum(input longint acc, output logic signed [31:0] val,
                              output logic ovf);
         longint shifted;
         shifted = acc >>> used_frac();
         ovf = 1'b1;
         if (shifted > 64'sd2147483647) val = 32'sh7fffffff;
         else if (shifted < -64'sd2147483648) val = 32'sh80000000;
         else begin
            val = shifted[31:0];
            ovf = 1'b0;
         end
      endfunction

      // state elements first, then y = C x, last flag on the final output
      function void push_run(logic [MAX_STATES-1:0] state_ovf);
         int unsigned       n;
         int unsigned       r;
         longint            acc;
         logic signed [31:0] val;
         logic              ovf;
         rsp_type           rsp;
         n = used_states();
         r = used_outputs();
         for (int i = 0; i < n; i++) begin
            rsp.kind         = KIND_STATE;
            rsp.index        = i[1:0];
            rsp.result_value = state_vec[i][31:0];
            rsp.overflow     = state_ovf[i];
            rsp.last         = 1'b0;
            queue_expected(rsp);
         end
         for (int i = 0; i < r; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc += coef_c[i*MAX_STATES+j] * state_vec[j];
            scale_sum(acc, val, ovf);
            rsp.kind         = KIND_OUTPUT;
            rsp.index        = i[1:0];
            rsp.result_value = val;
            rsp.overflow     = ovf;
            rsp.last         = (i == r - 1);
            queue_expected(rsp);
         end
      endfunction

      // x = A x + B u over the elements in use
      function void run_update();
         int unsigned        n;
         int unsigned        m;
         longint             acc;
         logic signed [31:0] val;
         logic               ovf;
         logic signed [31:0] next_state [MAX_STATES];
         logic [MAX_STATES-1:0] state_ovf;
         n = used_states();
         m = used_inputs();
         state_ovf = '0;
         for (int i = 0; i < n; i++) begin
            acc = 0;
            for (int j = 0; j < n; j++) acc += coef_a[i*MAX_STATES+j] * state_vec[j];
            for (int j = 0; j < m; j++) acc += coef_b[i*MAX_INPUTS+j] * input_vec[j];
            scale_sum(acc, val, ovf);
            next_state[i] = val;
            state_ovf[i]  = ovf;
         end
         for (int i = 0; i < n; i++) state_vec[i] = next_state[i];
         push_run(state_ovf);
      endfunction

      // apply one accepted request and queue the results it causes
      function void predict_request(req_type item);
         longint v;
         v = $signed(item.value);
         case (item.func)
            FUNC_LOAD_COEF: begin
               if (item.matrix_sel == MSEL_A && item.row < MAX_STATES && item.col < MAX_STATES)
                  coef_a[item.row*MAX_STATES+item.col] = v;
               else if (item.matrix_sel == MSEL_B && item.row < MAX_STATES &&
                        item.col < MAX_INPUTS)
                  coef_b[item.row*MAX_INPUTS+item.col] = v;
               else if (item.matrix_sel == MSEL_C && item.row < MAX_OUTPUTS &&
                        item.col < MAX_STATES)
                  coef_c[item.row*MAX_STATES+item.col] = v;
            end
            FUNC_SET_STATE: begin
               if (item.row < used_states()) state_vec[item.row] = v;
            end
            FUNC_REPORT: begin
               push_run('0);
            end
            FUNC_INPUT: begin
               if (item.col < used_inputs()) input_vec[item.col] = v;
               if (item.last_input) run_update();
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_rsps.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d index %0d value %0d",
                   got.kind, got.index, got.result_value);
            error_count++;
            return;
         end
         want = pending_rsps.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("index", want.index, got.index);
         compare_field("result_value", $signed(want.result_value), $signed(got.result_value));
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   ss_step_tracker tracker;
   int             items_sent = 0;
   int             req_idle_pct = 0;
   int             req_quiet_left = 0;
   int             rsp_stall_pct = 0;
   int             rsp_quiet_left = 0;

   // per-phase register settings and idling style
   int phase_states  [NUM_PHASES] = '{4, 1, 4, 0, 7, 2, 3, 4};
   int phase_inputs  [NUM_PHASES] = '{2, 1, 2, 0, 3, 1, 2, 2};
   int phase_outputs [NUM_PHASES] = '{2, 1, 2, 0, 3, 2, 1, 2};
   int phase_frac    [NUM_PHASES] = '{16, 0, 30, 31, 8, 12, 20, 4};
   int phase_idle    [NUM_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

   state_space_step i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure with occasional stall-free stretches
   always @(posedge clock) begin
      if (rsp_quiet_left > 0) begin
         rsp_quiet_left <= rsp_quiet_left - 1;
         rsp_stall      <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) rsp_quiet_left <= $urandom_range(20, 80);
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_result(rsp_data);
   end

   // mostly values near one in the current format, plus extremes and full range
   function automatic logic signed [31:0] draw_value();
      logic signed [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3:    return raw;
         default: return raw >>> (FRAC_MAX - tracker.used_frac());
      endcase
   endfunction

   function automatic req_type make_item(logic [1:0] func, logic [1:0] sel, logic [1:0] row,
                                         logic [1:0] col, logic signed [31:0] value,
                                         logic last_in);
      req_type item;
      item.func       = func;
      item.matrix_sel = sel;
      item.row        = row;
      item.col        = col;
      item.value      = value;
      item.last_input = last_in;
      return item;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_item(input req_type item);
      if (req_quiet_left > 0) req_quiet_left--;
      else if ($urandom_range(0, 39) == 0) req_quiet_left = $urandom_range(10, 30);
      while (req_quiet_left == 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.predict_request(item);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      tracker.write_csr(idx, data);
   endtask

   // drop valid, wait for every expected result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // coefficient loads, state sets, a full input vector ending in an update, at times a report
   task automatic send_sequence();
      logic [1:0]  sel;
      logic [1:0]  row;
      logic [1:0]  col;
      int unsigned n;
      int unsigned m;
      n = tracker.used_states();
      m = tracker.used_inputs();
      repeat ($urandom_range(0, 4)) begin
         sel = 2'($urandom_range(0, 2));
         row = 2'((sel == MSEL_C) ? $urandom_range(0, MAX_OUTPUTS - 1)
                                  : $urandom_range(0, MAX_STATES - 1));
         col = 2'((sel == MSEL_B) ? $urandom_range(0, MAX_INPUTS - 1)
                                  : $urandom_range(0, MAX_STATES - 1));
         send_item(make_item(FUNC_LOAD_COEF, sel, row, col, draw_value(), 1'($urandom)));
      end
      repeat ($urandom_range(0, 2)) begin
         row = 2'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                              : $urandom_range(0, n - 1));
         send_item(make_item(FUNC_SET_STATE, 2'($urandom), row, 2'($urandom), draw_value(),
                             1'($urandom)));
      end
      for (int j = 0; j < m; j++)
         send_item(make_item(FUNC_INPUT, 2'($urandom), 2'($urandom), 2'(j), draw_value(),
                             j == m - 1));
      if ($urandom_range(0, 4) == 0)
         send_item(make_item(FUNC_REPORT, 2'($urandom), 2'($urandom), 2'($urandom), $urandom,
                             1'($urandom)));
      // noise: any field combination at all
      if ($urandom_range(0, 5) == 0)
         send_item(make_item(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), $urandom,
                             1'($urandom)));
   endtask

   // extremes, ignored loads and sets, and the first reports and updates
   task automatic send_directed();
      send_item(make_item(FUNC_REPORT, MSEL_A, 2'd0, 2'd0, 32'sd0, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_A, 2'd0, 2'd0, 32'sh7fffffff, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_A, 2'd3, 2'd3, 32'sh80000000, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_A, 2'd1, 2'd2, 32'sh00010000, 1'b1));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_B, 2'd3, 2'd1, 32'sh00010000, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_B, 2'd0, 2'd2, -32'sd1, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_C, 2'd1, 2'd3, 32'shffff0000, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_C, 2'd0, 2'd0, 32'sh00010000, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_C, 2'd2, 2'd0, 32'sh12345678, 1'b0));
      send_item(make_item(FUNC_LOAD_COEF, MSEL_NONE, 2'd3, 2'd3, -32'sd1, 1'b1));
      send_item(make_item(FUNC_SET_STATE, MSEL_NONE, 2'd0, 2'd3, 32'sh7fffffff, 1'b0));
      send_item(make_item(FUNC_SET_STATE, MSEL_A, 2'd3, 2'd0, 32'sh80000000, 1'b1));
      send_item(make_item(FUNC_SET_STATE, MSEL_A, 2'd1, 2'd0, 32'sh00010000, 1'b0));
      send_item(make_item(FUNC_REPORT, MSEL_NONE, 2'd3, 2'd3, -32'sd1, 1'b1));
      send_item(make_item(FUNC_INPUT, MSEL_A, 2'd0, 2'd1, 32'sh00010000, 1'b0));
      // input element out of range still triggers the update
      send_item(make_item(FUNC_INPUT, MSEL_A, 2'd0, 2'd3, 32'sh7fffffff, 1'b1));
      send_item(make_item(FUNC_INPUT, MSEL_NONE, 2'd3, 2'd0, 32'sh80000000, 1'b1));
      send_item(make_item(FUNC_REPORT, MSEL_B, 2'd1, 2'd1, 32'sd0, 1'b0));
      send_item(make_item(FUNC_INPUT, MSEL_C, 2'd2, 2'd0, -32'sd5, 1'b1));
   endtask

   // main stimulus
   initial begin
      int start;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_reg(CSR_STATES_USED, CSR_DATA_W'(phase_states[p]));
         write_reg(CSR_INPUTS_USED, CSR_DATA_W'(phase_inputs[p]));
         write_reg(CSR_OUTPUTS_USED, CSR_DATA_W'(phase_outputs[p]));
         write_reg(CSR_FRAC_BITS, CSR_DATA_W'(phase_frac[p]));
         csr_write_en <= 1'b0;
         req_idle_pct  = (phase_idle[p] == IDLE_SENDER) ? 56 :
                         (phase_idle[p] == IDLE_BOTH) ? 18 : 0;
         rsp_stall_pct <= (phase_idle[p] == IDLE_RECEIVER) ? 56 :
                          (phase_idle[p] == IDLE_BOTH) ? 18 : 0;
         if (p == 0) send_directed();
         start = items_sent;
         while (items_sent - start < ITEMS_PER_PHASE) send_sequence();
         wait_idle();
      end
      if (tracker.error_count == 0 && tracker.pending_rsps.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/ss_step_pkg.sv
hdl/state_space_step.sv
tb/sv/tb_state_space_step.sv
